// ===== hdl/fic_pkg.sv =====
// Shared types, constants and the rounding-increment function for the float/int conversion pipeline.
package fic_pkg;

    localparam logic [2:0] K_F2U  = 3'd0;
    localparam logic [2:0] K_F2I  = 3'd1;
    localparam logic [2:0] K_U2F  = 3'd2;
    localparam logic [2:0] K_I2F  = 3'd3;
    localparam logic [2:0] K_SGNJ = 3'd4;

    localparam logic [2:0] RM_RNE = 3'd0;
    localparam logic [2:0] RM_RTZ = 3'd1;
    localparam logic [2:0] RM_RDN = 3'd2;
    localparam logic [2:0] RM_RUP = 3'd3;
    localparam logic [2:0] RM_RMM = 3'd4;

    localparam logic [2:0] SJ_COPY = 3'd0;
    localparam logic [2:0] SJ_NEG  = 3'd1;
    localparam logic [2:0] SJ_XOR  = 3'd2;

    localparam logic [7:0]  EXP_BIAS  = 8'd127;
    localparam logic [7:0]  EXP_ALL1  = 8'hFF;
    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] INT_MAX32 = 32'h7FFF_FFFF;

    // Work carried from the align stage into the round stage.
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  rm;
        logic        sign;
        logic        invalid;
        logic        is_zero;
        logic [31:0] mag;
        logic [7:0]  exp;
        logic        g;
        logic        r;
        logic        s;
        logic [31:0] sj;
    } t_align;

    function automatic logic round_inc(input logic [2:0] rm, input logic sign,
                                       input logic lsb, input logic g,
                                       input logic r, input logic s);
        logic inc;
        begin
            case (rm)
                RM_RNE:  inc = g & (lsb | r | s);
                RM_RDN:  inc = sign & (g | r | s);
                RM_RUP:  inc = ~sign & (g | r | s);
                RM_RMM:  inc = g;
                default: inc = 1'b0;
            endcase
            return inc;
        end
    endfunction

endpackage

// ===== hdl/fic_decode.sv =====
// Stage 1: unpack the beat, find the leading-one position and form the sign-injection result.
module fic_decode import fic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [2:0]  i_rm,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_rm,
    output logic        o_sign,
    output logic [31:0] o_val,
    output logic [4:0]  o_msb,
    output logic [31:0] o_sj
);
    logic        r_valid;
    logic [2:0]  r_kind, r_rm;
    logic        r_sign;
    logic [31:0] r_val, r_sj;
    logic [4:0]  r_msb;
    logic        n_sign;
    logic [31:0] n_val, n_sj;
    logic [4:0]  n_msb;

    always_comb begin
        n_sign = i_a[31];
        n_val  = i_a;
        if (i_kind == K_U2F) begin
            n_sign = 1'b0;
        end else if (i_kind == K_I2F && i_a[31]) begin
            n_val = 32'd0 - i_a;
        end else if (i_kind == K_I2F) begin
            n_sign = 1'b0;
        end
        n_msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (n_val[i]) n_msb = 5'(i);
        end
        case (i_rm)
            SJ_COPY: n_sj = (i_b & SIGN_BIT) | (i_a & INT_MAX32);
            SJ_NEG:  n_sj = (~i_b & SIGN_BIT) | (i_a & INT_MAX32);
            SJ_XOR:  n_sj = ((i_a ^ i_b) & SIGN_BIT) | (i_a & INT_MAX32);
            default: n_sj = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_kind <= i_kind;
            r_rm   <= i_rm;
            r_sign <= n_sign;
            r_val  <= n_val;
            r_msb  <= n_msb;
            r_sj   <= n_sj;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_rm    = r_rm;
    assign o_sign  = r_sign;
    assign o_val   = r_val;
    assign o_msb   = r_msb;
    assign o_sj    = r_sj;
endmodule

// ===== hdl/fic_align.sv =====
// Stage 2: shift the significand into place and form guard, round and sticky bits.
module fic_align import fic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_rm,
    input  logic        i_sign,
    input  logic [31:0] i_val,
    input  logic [4:0]  i_msb,
    input  logic [31:0] i_sj,
    output logic        o_valid,
    output t_align      o_al
);
    logic   r_valid;
    t_align r_al;
    t_align n_al;

    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic signed [9:0] sh;
    logic [4:0]  rs;
    logic [55:0] wide;
    logic [31:0] iabs;
    logic [63:0] iwide;
    logic [4:0]  irs;

    always_comb begin
        n_al      = '0;
        n_al.kind = i_kind;
        n_al.rm   = i_rm;
        n_al.sign = i_sign;
        n_al.sj   = i_sj;
        e   = i_val[30:23];
        m   = i_val[22:0];
        sig = {1'b1, m};
        sh  = 10'($signed({2'b00, e})) - 10'sd127;
        rs  = 5'd0;
        wide = '0;
        iabs = i_val;
        iwide = '0;
        irs = 5'd0;
        if (i_kind == K_F2U || i_kind == K_F2I) begin
            if (e == EXP_ALL1 || sh > ((i_kind == K_F2I) ? 10'sd30 : 10'sd31)) begin
                if (i_kind == K_F2I && sh == 10'sd31 && m == 23'd0 && i_sign)
                    n_al.mag = SIGN_BIT;
                else
                    n_al.invalid = 1'b1;
            end else if (e == 8'd0) begin
                n_al.s = (m != 23'd0);
            end else if (sh >= 10'sd23) begin
                n_al.mag = {8'd0, sig} << (sh[4:0] - 5'd23);
            end else if (sh >= 10'sd0) begin
                rs = 5'd23 - sh[4:0];
                // Low 24 bits below the binary point carry g, r and sticky.
                wide = {8'd0, sig, 24'd0} >> rs;
                n_al.mag = wide[55:24];
                n_al.g = wide[23];
                n_al.r = wide[22];
                n_al.s = (wide[21:0] != 22'd0);
            end else if (sh == -10'sd1) begin
                n_al.g = 1'b1;
                n_al.r = m[22];
                n_al.s = (m[21:0] != 22'd0);
            end else if (sh == -10'sd2) begin
                n_al.r = 1'b1;
                n_al.s = (m != 23'd0);
            end else begin
                n_al.s = 1'b1;
            end
        end else begin
            n_al.is_zero = (iabs == 32'd0);
            n_al.exp = EXP_BIAS + {3'd0, i_msb};
            if (i_msb > 5'd23) begin
                irs = i_msb - 5'd23;
                iwide = {iabs, 32'd0} >> irs;
                n_al.mag = {9'd0, iwide[54:32]};
                n_al.g = iwide[31];
                n_al.r = iwide[30];
                n_al.s = (iwide[29:0] != 30'd0);
            end else begin
                n_al.mag = {9'd0, 23'(iabs << (5'd23 - i_msb))};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_al <= n_al;
        end
    end

    assign o_valid = r_valid;
    assign o_al    = r_al;
endmodule

// ===== hdl/fic_round.sv =====
// Stage 3: round, saturate and pack the result.
module fic_round import fic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_align      i_al,
    output logic        o_valid,
    output logic [31:0] o_result
);
    logic        r_valid;
    logic [31:0] r_result;
    logic [31:0] n_result;
    logic        inc;
    logic [32:0] mag;
    logic [23:0] mant;
    logic [7:0]  ex;

    always_comb begin
        inc  = round_inc(i_al.rm, i_al.sign, i_al.mag[0], i_al.g, i_al.r, i_al.s);
        mag  = {1'b0, i_al.mag} + {32'd0, inc};
        mant = i_al.mag[23:0] + {23'd0, inc};
        ex   = i_al.exp;
        n_result = 32'd0;
        case (i_al.kind)
            K_F2U: begin
                if (i_al.invalid || (i_al.sign && mag != 33'd0)) n_result = ALL_ONES;
                else n_result = mag[31:0];
            end
            K_F2I: begin
                if (i_al.invalid) n_result = SIGN_BIT;
                else if (!i_al.sign && mag > {1'b0, INT_MAX32}) n_result = SIGN_BIT;
                else if (i_al.sign && mag > {1'b0, SIGN_BIT}) n_result = SIGN_BIT;
                else if (i_al.sign) n_result = 32'd0 - mag[31:0];
                else n_result = mag[31:0];
            end
            K_U2F, K_I2F: begin
                if (mant[23]) begin
                    mant = 24'd0;
                    ex   = ex + 8'd1;
                end
                n_result = i_al.is_zero ? 32'd0 : {i_al.sign, ex, mant[22:0]};
            end
            K_SGNJ:  n_result = i_al.sj;
            default: n_result = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// ===== hdl/float_int_converter_top.sv =====
// Top level of the binary32/int32 conversion and sign-injection pipeline.
// Three register stages (decode and leading-one search, align with guard/round/sticky,
// round and pack) take one beat per cycle while the output is not stalled; a beat moves
// through the decode, align and round registers in turn. The whole pipe advances
// when the output register is empty or being taken, so back pressure stalls every stage
// together. Kinds 5 to 7 give no result beat.
module float_int_converter_top import fic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // operand_a[31:0], operand_b[63:32], rounding_mode[66:64]
    input  logic [2:0]  s_axis_tuser,  // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // result[31:0]
);
    logic        en;
    logic        in_ok;
    logic        d_valid, a_valid;
    logic [2:0]  d_kind, d_rm;
    logic        d_sign;
    logic [31:0] d_val, d_sj;
    logic [4:0]  d_msb;
    t_align      a_al;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    // Unused kinds are dropped at the door.
    assign in_ok = s_axis_tvalid && (s_axis_tuser <= K_SGNJ);

    fic_decode u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(in_ok),
        .i_kind(s_axis_tuser), .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]),
        .i_rm(s_axis_tdata[66:64]),
        .o_valid(d_valid), .o_kind(d_kind), .o_rm(d_rm), .o_sign(d_sign),
        .o_val(d_val), .o_msb(d_msb), .o_sj(d_sj)
    );

    fic_align u_al (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_valid),
        .i_kind(d_kind), .i_rm(d_rm), .i_sign(d_sign), .i_val(d_val),
        .i_msb(d_msb), .i_sj(d_sj),
        .o_valid(a_valid), .o_al(a_al)
    );

    fic_round u_rnd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(a_valid),
        .i_al(a_al),
        .o_valid(m_axis_tvalid), .o_result(m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipe stalled");
    a_unused_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser > K_SGNJ |=> !d_valid)
        else $error("unused kind entered pipe");
`endif
endmodule
